### hdl/mlft_pkg.sv
// Shared types, constants and register codes of the MAC learning forward table.
package mlft_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int NUM_PORTS_DEF     = 16;

    localparam int MAC_W  = 48;
    localparam int PORT_W = 5;
    localparam int TYPE_W = 16;
    localparam int AGE_W  = 8;
    localparam int ACT_W  = 2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FLOOD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DROP    = 2'd2;

    localparam logic [1:0] REG_AGING_START  = 2'd0;
    localparam logic [1:0] REG_DATA_TYPE    = 2'd1;
    localparam logic [1:0] REG_CONTROL_TYPE = 2'd2;

    localparam logic [AGE_W-1:0]  AGING_START_RST  = 8'd10;
    localparam logic [TYPE_W-1:0] DATA_TYPE_RST    = 16'd0;
    localparam logic [TYPE_W-1:0] CONTROL_TYPE_RST = 16'd1;

    typedef struct packed {
        logic [AGE_W-1:0]  aging_start;
        logic [TYPE_W-1:0] data_type_code;
        logic [TYPE_W-1:0] control_type_code;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [AGE_W-1:0]  age;
    } entry_t;

endpackage

### hdl/mlft_if.sv
// Handshake channels for frame header words and forwarding verdict words.
interface mlft_frame_if import mlft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] in_port;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [TYPE_W-1:0] eth_type;

    modport source (output valid, in_port, src_mac, dst_mac, eth_type, input ready);
    modport sink (input valid, in_port, src_mac, dst_mac, eth_type, output ready);
    modport monitor (input valid, ready, in_port, src_mac, dst_mac, eth_type);
endinterface

interface mlft_verdict_if import mlft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [PORT_W-1:0] out_port;
    logic              learn_full;

    modport source (output valid, action, out_port, learn_full, input ready);
    modport sink (input valid, action, out_port, learn_full, output ready);
    modport monitor (input valid, ready, action, out_port, learn_full);
endinterface

### hdl/mac_learning_forward_table.sv
// Top level of the MAC learning forward table.
// One frame header word is taken at a time. A data frame walks the table once,
// matching source and destination together, then learns or refreshes its source
// and presents the verdict. A control frame reads every entry and rewrites each
// valid one in a single pipelined pass; any other type, or a data frame from an
// invalid port, goes straight to the verdict. After reset a clearing pass runs
// before the first header is taken; register writes are accepted throughout. A
// finished verdict waits in an output register while the next header is taken.
module mac_learning_forward_table import mlft_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int NUM_PORTS     = NUM_PORTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mlft_frame_if.sink            frame,
    mlft_verdict_if.source        verdict,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    cfg_t             cfg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    mlft_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlft_table_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_table_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mlft_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NUM_PORTS     (NUM_PORTS),
        .IDX_W         (IDX_W)
    ) u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .frame   (frame),
        .verdict (verdict),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### hdl/mlft_cfg_regs.sv
// APB configuration registers of the MAC learning forward table.
module mlft_cfg_regs import mlft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_AGING_START:  cfg_next.aging_start       = pwdata[AGE_W-1:0];
                REG_DATA_TYPE:    cfg_next.data_type_code    = pwdata[TYPE_W-1:0];
                REG_CONTROL_TYPE: cfg_next.control_type_code = pwdata[TYPE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_AGING_START:  prdata = APB_DATA_W'(cfg_reg.aging_start);
            REG_DATA_TYPE:    prdata = APB_DATA_W'(cfg_reg.data_type_code);
            REG_CONTROL_TYPE: prdata = APB_DATA_W'(cfg_reg.control_type_code);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.aging_start       <= AGING_START_RST;
            cfg_reg.data_type_code    <= DATA_TYPE_RST;
            cfg_reg.control_type_code <= CONTROL_TYPE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/mlft_table_mem.sv
// Single-port-write, registered-read memory holding the MAC table entries.
module mlft_table_mem import mlft_pkg::*;
#(
    parameter int DEPTH  = TABLE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

### hdl/mlft_engine.sv
// Sequencer that scans, learns, ages and issues verdicts over the table memory.
module mlft_engine import mlft_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int NUM_PORTS     = NUM_PORTS_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    mlft_frame_if.sink         frame,
    mlft_verdict_if.source     verdict,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output entry_t             wr_data,
    output logic               rd_en,
    output logic [IDX_W-1:0]   rd_addr,
    input  entry_t             rd_data
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SCAN_END = 3'd3;
    localparam logic [2:0] S_UPDATE   = 3'd4;
    localparam logic [2:0] S_AGE      = 3'd5;
    localparam logic [2:0] S_AGE_END  = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [6:0]       MAX_PORT = 7'(NUM_PORTS);

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic [MAC_W-1:0]  src_reg, src_next;
    logic [MAC_W-1:0]  dst_reg, dst_next;
    logic              src_hit_reg, src_hit_next;
    logic [IDX_W-1:0]  src_idx_reg, src_idx_next;
    logic [PORT_W-1:0] src_port_reg, src_port_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              dst_hit_reg, dst_hit_next;
    logic [PORT_W-1:0] dst_port_reg, dst_port_next;
    logic [ACT_W-1:0]  pend_action_reg, pend_action_next;
    logic [PORT_W-1:0] pend_port_reg, pend_port_next;
    logic              pend_full_reg, pend_full_next;
    logic              out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]  out_action_reg, out_action_next;
    logic [PORT_W-1:0] out_port_reg, out_port_next;
    logic              out_full_reg, out_full_next;

    logic              port_ok;
    logic              d_hit;
    logic [PORT_W-1:0] d_port;
    logic [AGE_W-1:0]  age_dec;

    assign frame.ready        = (state_reg == S_IDLE);
    assign verdict.valid      = out_valid_reg;
    assign verdict.action     = out_action_reg;
    assign verdict.out_port   = out_port_reg;
    assign verdict.learn_full = out_full_reg;

    assign port_ok = (frame.in_port != '0) && (7'(frame.in_port) <= MAX_PORT);
    assign age_dec = rd_data.age - AGE_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        rd_valid_next    = 1'b0;
        rd_addr_next     = addr_reg;
        port_next        = port_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        src_hit_next     = src_hit_reg;
        src_idx_next     = src_idx_reg;
        src_port_next    = src_port_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        dst_hit_next     = dst_hit_reg;
        dst_port_next    = dst_port_reg;
        pend_action_next = pend_action_reg;
        pend_port_next   = pend_port_reg;
        pend_full_next   = pend_full_reg;
        out_valid_next   = out_valid_reg && !verdict.ready;
        out_action_next  = out_action_reg;
        out_port_next    = out_port_reg;
        out_full_next    = out_full_reg;
        wr_en            = 1'b0;
        wr_addr          = addr_reg;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = addr_reg;
        d_hit            = dst_hit_reg;
        d_port           = dst_port_reg;

        // scan result stage
        if (rd_valid_reg && (state_reg == S_SCAN || state_reg == S_SCAN_END))
        begin
            if (!src_hit_reg && rd_data.valid && rd_data.mac == src_reg)
            begin
                src_hit_next  = 1'b1;
                src_idx_next  = rd_addr_reg;
                src_port_next = rd_data.port;
            end
            if (!free_found_reg && !rd_data.valid)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_addr_reg;
            end
            if (!dst_hit_reg && rd_data.valid && rd_data.mac == dst_reg)
            begin
                dst_hit_next  = 1'b1;
                dst_port_next = rd_data.port;
            end
        end

        // age write-back stage; never collides with the read one address ahead
        if (rd_valid_reg && (state_reg == S_AGE || state_reg == S_AGE_END) && rd_data.valid)
        begin
            wr_en         = 1'b1;
            wr_addr       = rd_addr_reg;
            wr_data.valid = (age_dec != '0);
            wr_data.mac   = rd_data.mac;
            wr_data.port  = rd_data.port;
            wr_data.age   = age_dec;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_reg;
                wr_data = '0;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (frame.valid)
                begin
                    port_next       = frame.in_port;
                    src_next        = frame.src_mac;
                    dst_next        = frame.dst_mac;
                    src_hit_next    = 1'b0;
                    free_found_next = 1'b0;
                    dst_hit_next    = 1'b0;
                    addr_next       = '0;
                    pend_action_next = ACT_DROP;
                    pend_port_next   = '0;
                    pend_full_next   = 1'b0;
                    if (frame.eth_type == cfg.data_type_code)
                    begin
                        state_next = port_ok ? S_SCAN : S_DONE;
                    end
                    else if (frame.eth_type == cfg.control_type_code)
                    begin
                        state_next = S_AGE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN, S_AGE:
            begin
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                rd_addr_next  = addr_reg;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = (state_reg == S_SCAN) ? S_SCAN_END : S_AGE_END;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            S_SCAN_END:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (src_hit_reg)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = src_idx_reg;
                    wr_data.valid = 1'b1;
                    wr_data.mac   = src_reg;
                    wr_data.port  = src_port_reg;
                    wr_data.age   = cfg.aging_start;
                end
                else if (free_found_reg)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = free_idx_reg;
                    wr_data.valid = 1'b1;
                    wr_data.mac   = src_reg;
                    wr_data.port  = port_reg;
                    wr_data.age   = cfg.aging_start;
                end
                // destination equal to a freshly learned source
                if (!dst_hit_reg && !src_hit_reg && free_found_reg && src_reg == dst_reg)
                begin
                    d_hit  = 1'b1;
                    d_port = port_reg;
                end
                pend_full_next = !src_hit_reg && !free_found_reg;
                if (!d_hit)
                begin
                    pend_action_next = ACT_FLOOD;
                    pend_port_next   = '0;
                end
                else if (d_port == port_reg)
                begin
                    pend_action_next = ACT_DROP;
                    pend_port_next   = '0;
                end
                else
                begin
                    pend_action_next = ACT_FORWARD;
                    pend_port_next   = d_port;
                end
                state_next = S_DONE;
            end
            S_AGE_END:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || verdict.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = pend_action_reg;
                    out_port_next   = pend_port_reg;
                    out_full_next   = pend_full_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg     <= rd_addr_next;
        port_reg        <= port_next;
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        src_hit_reg     <= src_hit_next;
        src_idx_reg     <= src_idx_next;
        src_port_reg    <= src_port_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        dst_hit_reg     <= dst_hit_next;
        dst_port_reg    <= dst_port_next;
        pend_action_reg <= pend_action_next;
        pend_port_reg   <= pend_port_next;
        pend_full_reg   <= pend_full_next;
        out_action_reg  <= out_action_next;
        out_port_reg    <= out_port_next;
        out_full_reg    <= out_full_next;
    end

endmodule

### hdl/mlft_checker.sv
// Port-level assertions for the MAC learning forward table, bound to the top level.
module mlft_checker import mlft_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              frame_valid,
    input logic              frame_ready,
    input logic              verdict_valid,
    input logic              verdict_ready,
    input logic [ACT_W-1:0]  action,
    input logic [PORT_W-1:0] out_port,
    input logic              learn_full
);

    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !verdict_ready |=> verdict_valid && $stable(action)
            && $stable(out_port) && $stable(learn_full))
        else $error("verdict word changed while stalled");

    a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && action != ACT_FORWARD |-> out_port == '0)
        else $error("out_port set on a non-forward verdict");

    a_forward_port: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && action == ACT_FORWARD |-> out_port != '0)
        else $error("forward verdict to port zero");

    a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !frame_ready)
        else $error("header taken during the clearing pass");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready |=> !frame_ready)
        else $error("header taken while the previous one is in progress");

endmodule

bind mac_learning_forward_table mlft_checker u_mlft_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_valid   (frame.valid),
    .frame_ready   (frame.ready),
    .verdict_valid (verdict.valid),
    .verdict_ready (verdict.ready),
    .action        (verdict.action),
    .out_port      (verdict.out_port),
    .learn_full    (verdict.learn_full)
);
